// ===== rtl/ucd_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, divider constants and the month table of the civil date converter.
package ucd_pkg;

  localparam int SECS_W  = 64;
  localparam int YEAR_W  = 40;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;

  localparam int DAY_K      = 15;
  localparam int DAY_CHUNKS = 5;
  localparam int DAY_WW     = DAY_K * DAY_CHUNKS;
  localparam int DAY_RW     = 17;
  localparam int DAY_VW     = DAY_RW + DAY_K;
  localparam int DAY_MW     = 33;
  localparam int DAY_PW     = DAY_VW + DAY_MW;
  localparam int DAY_SH     = DAY_VW + DAY_RW;
  localparam logic [DAY_RW-1:0] SECS_PER_DAY = DAY_RW'(86400);
  localparam logic [DAY_MW-1:0] DAY_M =
      DAY_MW'((64'd1 << DAY_SH) / 64'd86400 + 64'd1);

  localparam int DAYS_W = 48;
  localparam int Z_W    = 49;
  localparam logic [Z_W-1:0] EPOCH_SHIFT = Z_W'(719468);

  localparam int ERA_K      = 14;
  localparam int ERA_CHUNKS = 4;
  localparam int ERA_WW     = ERA_K * ERA_CHUNKS;
  localparam int ERA_RW     = 18;
  localparam int ERA_VW     = ERA_RW + ERA_K;
  localparam int ERA_MW     = 33;
  localparam int ERA_PW     = ERA_VW + ERA_MW;
  localparam int ERA_SH     = ERA_VW + ERA_RW;
  localparam logic [ERA_RW-1:0] DAYS_PER_ERA = ERA_RW'(146097);
  localparam logic [ERA_MW-1:0] ERA_M =
      ERA_MW'((64'd1 << ERA_SH) / 64'd146097 + 64'd1);
  localparam int ERA_W = 31;

  localparam int SOD_W = DAY_RW;
  localparam int DOE_W = ERA_RW;
  localparam int TR_W  = 12;

  localparam int HOUR_MW = 18;
  localparam int HOUR_SH = SOD_W + 12;
  localparam logic [HOUR_MW-1:0] HOUR_M = HOUR_MW'((64'd1 << HOUR_SH) / 64'd3600 + 64'd1);
  localparam logic [TR_W-1:0] SECS_PER_HOUR = TR_W'(3600);

  localparam int MIN_MW = 13;
  localparam int MIN_SH = TR_W + 6;
  localparam logic [MIN_MW-1:0] MIN_M = MIN_MW'((64'd1 << MIN_SH) / 64'd60 + 64'd1);
  localparam logic [TR_W-1:0] SECS_PER_MIN = TR_W'(60);

  localparam int C4_W   = 7;
  localparam int C4_MW  = 19;
  localparam int C4_SH  = DOE_W + 11;
  localparam logic [C4_MW-1:0] C4_M = C4_MW'((64'd1 << C4_SH) / 64'd1460 + 64'd1);

  localparam int C100_W  = 3;
  localparam int C100_MW = 19;
  localparam int C100_SH = DOE_W + 16;
  localparam logic [C100_MW-1:0] C100_M =
      C100_MW'((64'd1 << C100_SH) / 64'd36524 + 64'd1);

  localparam logic [DOE_W-1:0] DOE_LAST = DOE_W'(146096);

  localparam int YOE_W  = 9;
  localparam int YOE_MW = 19;
  localparam int YOE_SH = DOE_W + 9;
  localparam logic [YOE_MW-1:0] YOE_M = YOE_MW'((64'd1 << YOE_SH) / 64'd365 + 64'd1);
  localparam logic [DOE_W-1:0] DAYS_PER_YEAR = DOE_W'(365);

  localparam int Y100_W  = 2;
  localparam int Y100_MW = 10;
  localparam int Y100_SH = YOE_W + 7;
  localparam logic [Y100_MW-1:0] Y100_M =
      Y100_MW'((64'd1 << Y100_SH) / 64'd100 + 64'd1);

  localparam int DOY_W = 9;
  localparam int V5_W  = 11;
  localparam int MP_W  = 4;
  localparam int MP_MW = 12;
  localparam int MP_SH = V5_W + 8;
  localparam logic [MP_MW-1:0] MP_M = MP_MW'((64'd1 << MP_SH) / 64'd153 + 64'd1);

  localparam logic [MP_W-1:0] MP_JAN = MP_W'(10);
  localparam logic [YEAR_W-1:0] YEARS_PER_ERA = YEAR_W'(400);

  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] ms;
    unique case (mp)
      4'd0:    ms = 9'd0;
      4'd1:    ms = 9'd31;
      4'd2:    ms = 9'd61;
      4'd3:    ms = 9'd92;
      4'd4:    ms = 9'd122;
      4'd5:    ms = 9'd153;
      4'd6:    ms = 9'd184;
      4'd7:    ms = 9'd214;
      4'd8:    ms = 9'd245;
      4'd9:    ms = 9'd275;
      4'd10:   ms = 9'd306;
      4'd11:   ms = 9'd337;
      default: ms = 9'd0;
    endcase
    return ms;
  endfunction

endpackage

// ===== rtl/ucd_in_if.sv =====
`timescale 1ns / 1ps
// Timestamp request channel of the civil date converter.
interface ucd_in_if;
  logic                        valid;
  logic                        ready;
  logic [ucd_pkg::SECS_W-1:0]  unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink (input valid, input unix_seconds, output ready);
endinterface

// ===== rtl/ucd_out_if.sv =====
`timescale 1ns / 1ps
// Civil date and time result channel of the civil date converter.
interface ucd_out_if;
  logic                         valid;
  logic                         ready;
  logic [ucd_pkg::YEAR_W-1:0]   year;
  logic [ucd_pkg::MONTH_W-1:0]  month;
  logic [ucd_pkg::DAY_W-1:0]    day;
  logic [ucd_pkg::HOUR_W-1:0]   hour;
  logic [ucd_pkg::MIN_W-1:0]    minute;
  logic [ucd_pkg::SEC_W-1:0]    second;

  modport source (output valid, output year, output month, output day,
                  output hour, output minute, output second, input ready);
  modport sink (input valid, input year, input month, input day,
                input hour, input minute, input second, output ready);
endinterface

// ===== rtl/unix_seconds_to_civil_datetime.sv =====
`timescale 1ns / 1ps
// Pipelined conversion of Unix seconds to Gregorian date and UTC time of day.
//
//   channel  role  payload
//   stamp    sink  unix_seconds[63:0]
//   civil    src   year[39:0] month[3:0] day[4:0] hour[4:0] minute[5:0] second[5:0]
//
// One request per cycle while civil is taken or a stage is empty. Depth is set by
// two chunked constant dividers (by 86400 in five 15-bit chunks, by 146097 in four
// 14-bit chunks, two stages per chunk), an epoch-shift stage and eight date/time
// stages. Synchronous reset clears the valid bits only.
// A stage holds while it and every later stage are full and civil is not
// taken; empty stages keep filling, so bubbles close up.
module unix_seconds_to_civil_datetime (
  input  logic          clk,
  input  logic          rst,
  ucd_in_if.sink        stamp,
  ucd_out_if.source     civil
);

  localparam int ST_Z  = 2 * ucd_pkg::DAY_CHUNKS;
  localparam int ST_E  = ST_Z + 1;
  localparam int ST_Y  = ST_E + 2 * ucd_pkg::ERA_CHUNKS;
  localparam int NSTG  = ST_Y + 8;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  for (genvar i = 0; i < NSTG; i++) begin : g_en
    assign en[i] = civil.ready || !(&vld[NSTG-1:i]);
  end

  assign stamp.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= stamp.valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // seconds / 86400, one chunk per stage pair
  logic [ucd_pkg::DAY_WW-1:0] dw_a [ucd_pkg::DAY_CHUNKS];
  logic [ucd_pkg::DAY_VW-1:0] dv_a [ucd_pkg::DAY_CHUNKS];
  logic [ucd_pkg::DAY_K-1:0]  dq_a [ucd_pkg::DAY_CHUNKS];
  logic [ucd_pkg::DAY_WW-1:0] dw_b [ucd_pkg::DAY_CHUNKS];
  logic [ucd_pkg::DAY_RW-1:0] dr_b [ucd_pkg::DAY_CHUNKS];

  for (genvar j = 0; j < ucd_pkg::DAY_CHUNKS; j++) begin : g_day
    logic [ucd_pkg::DAY_WW-1:0] w_in;
    logic [ucd_pkg::DAY_RW-1:0] r_in;
    logic [ucd_pkg::DAY_VW-1:0] v_in;
    logic [ucd_pkg::DAY_PW-1:0] prod;

    if (j == 0) begin : g_first
      assign w_in = ucd_pkg::DAY_WW'(stamp.unix_seconds);
      assign r_in = '0;
    end else begin : g_next
      assign w_in = dw_b[j-1];
      assign r_in = dr_b[j-1];
    end

    assign v_in = {r_in, w_in[ucd_pkg::DAY_WW-1 -: ucd_pkg::DAY_K]};
    assign prod = ucd_pkg::DAY_PW'(v_in) * ucd_pkg::DAY_PW'(ucd_pkg::DAY_M);

    always_ff @(posedge clk) begin
      if (en[2*j]) begin
        dw_a[j] <= w_in;
        dv_a[j] <= v_in;
        dq_a[j] <= prod[ucd_pkg::DAY_SH +: ucd_pkg::DAY_K];
      end
    end

    always_ff @(posedge clk) begin
      if (en[2*j+1]) begin
        dw_b[j] <= {dw_a[j][ucd_pkg::DAY_WW-ucd_pkg::DAY_K-1:0], dq_a[j]};
        dr_b[j] <= ucd_pkg::DAY_RW'(dv_a[j] - ucd_pkg::DAY_VW'(dq_a[j]) *
                                   ucd_pkg::DAY_VW'(ucd_pkg::SECS_PER_DAY));
      end
    end
  end

  // shift so that day 0 is 0000-03-01
  logic [ucd_pkg::Z_W-1:0]   z;
  logic [ucd_pkg::SOD_W-1:0] z_sod;

  always_ff @(posedge clk) begin
    if (en[ST_Z]) begin
      z     <= ucd_pkg::Z_W'(dw_b[ucd_pkg::DAY_CHUNKS-1][ucd_pkg::DAYS_W-1:0]) +
               ucd_pkg::EPOCH_SHIFT;
      z_sod <= dr_b[ucd_pkg::DAY_CHUNKS-1];
    end
  end

  // day number / 146097
  logic [ucd_pkg::ERA_WW-1:0] ew_a [ucd_pkg::ERA_CHUNKS];
  logic [ucd_pkg::ERA_VW-1:0] ev_a [ucd_pkg::ERA_CHUNKS];
  logic [ucd_pkg::ERA_K-1:0]  eq_a [ucd_pkg::ERA_CHUNKS];
  logic [ucd_pkg::SOD_W-1:0]  es_a [ucd_pkg::ERA_CHUNKS];
  logic [ucd_pkg::ERA_WW-1:0] ew_b [ucd_pkg::ERA_CHUNKS];
  logic [ucd_pkg::ERA_RW-1:0] er_b [ucd_pkg::ERA_CHUNKS];
  logic [ucd_pkg::SOD_W-1:0]  es_b [ucd_pkg::ERA_CHUNKS];

  for (genvar j = 0; j < ucd_pkg::ERA_CHUNKS; j++) begin : g_era
    logic [ucd_pkg::ERA_WW-1:0] w_in;
    logic [ucd_pkg::ERA_RW-1:0] r_in;
    logic [ucd_pkg::SOD_W-1:0]  s_in;
    logic [ucd_pkg::ERA_VW-1:0] v_in;
    logic [ucd_pkg::ERA_PW-1:0] prod;

    if (j == 0) begin : g_first
      assign w_in = ucd_pkg::ERA_WW'(z);
      assign r_in = '0;
      assign s_in = z_sod;
    end else begin : g_next
      assign w_in = ew_b[j-1];
      assign r_in = er_b[j-1];
      assign s_in = es_b[j-1];
    end

    assign v_in = {r_in, w_in[ucd_pkg::ERA_WW-1 -: ucd_pkg::ERA_K]};
    assign prod = ucd_pkg::ERA_PW'(v_in) * ucd_pkg::ERA_PW'(ucd_pkg::ERA_M);

    always_ff @(posedge clk) begin
      if (en[ST_E+2*j]) begin
        ew_a[j] <= w_in;
        ev_a[j] <= v_in;
        eq_a[j] <= prod[ucd_pkg::ERA_SH +: ucd_pkg::ERA_K];
        es_a[j] <= s_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_E+2*j+1]) begin
        ew_b[j] <= {ew_a[j][ucd_pkg::ERA_WW-ucd_pkg::ERA_K-1:0], eq_a[j]};
        er_b[j] <= ucd_pkg::ERA_RW'(ev_a[j] - ucd_pkg::ERA_VW'(eq_a[j]) *
                                   ucd_pkg::ERA_VW'(ucd_pkg::DAYS_PER_ERA));
        es_b[j] <= es_a[j];
      end
    end
  end

  logic [ucd_pkg::ERA_W-1:0] era;
  logic [ucd_pkg::DOE_W-1:0] doe;
  logic [ucd_pkg::SOD_W-1:0] sod;

  assign era = ew_b[ucd_pkg::ERA_CHUNKS-1][ucd_pkg::ERA_W-1:0];
  assign doe = er_b[ucd_pkg::ERA_CHUNKS-1];
  assign sod = es_b[ucd_pkg::ERA_CHUNKS-1];

  // stage 1: century and four-year corrections, hour
  logic [36:0] c4_prod;
  logic [36:0] c100_prod;
  logic [34:0] hour_prod;

  assign c4_prod   = 37'(doe) * 37'(ucd_pkg::C4_M);
  assign c100_prod = 37'(doe) * 37'(ucd_pkg::C100_M);
  assign hour_prod = 35'(sod) * 35'(ucd_pkg::HOUR_M);

  logic [ucd_pkg::DOE_W-1:0]   y1_doe;
  logic [ucd_pkg::YEAR_W-1:0]  y1_era400;
  logic [ucd_pkg::C4_W-1:0]    y1_qa;
  logic [ucd_pkg::C100_W-1:0]  y1_qb;
  logic                        y1_qc;
  logic [ucd_pkg::SOD_W-1:0]   y1_sod;
  logic [ucd_pkg::HOUR_W-1:0]  y1_hour;

  always_ff @(posedge clk) begin
    if (en[ST_Y]) begin
      y1_doe    <= doe;
      y1_era400 <= ucd_pkg::YEAR_W'(era) * ucd_pkg::YEARS_PER_ERA;
      y1_qa     <= c4_prod[ucd_pkg::C4_SH +: ucd_pkg::C4_W];
      y1_qb     <= c100_prod[ucd_pkg::C100_SH +: ucd_pkg::C100_W];
      y1_qc     <= (doe == ucd_pkg::DOE_LAST);
      y1_sod    <= sod;
      y1_hour   <= hour_prod[ucd_pkg::HOUR_SH +: ucd_pkg::HOUR_W];
    end
  end

  // stage 2: corrected day of era, second of hour
  logic [ucd_pkg::DOE_W-1:0]   y2_doe;
  logic [ucd_pkg::YEAR_W-1:0]  y2_era400;
  logic [ucd_pkg::DOE_W-1:0]   y2_t;
  logic [ucd_pkg::HOUR_W-1:0]  y2_hour;
  logic [ucd_pkg::TR_W-1:0]    y2_tr;

  always_ff @(posedge clk) begin
    if (en[ST_Y+1]) begin
      y2_doe    <= y1_doe;
      y2_era400 <= y1_era400;
      y2_t      <= y1_doe - ucd_pkg::DOE_W'(y1_qa) + ucd_pkg::DOE_W'(y1_qb) -
                   ucd_pkg::DOE_W'(y1_qc);
      y2_hour   <= y1_hour;
      y2_tr     <= ucd_pkg::TR_W'(y1_sod - ucd_pkg::SOD_W'(y1_hour) *
                                  ucd_pkg::SOD_W'(ucd_pkg::SECS_PER_HOUR));
    end
  end

  // stage 3: year of era, minute
  logic [36:0] yoe_prod;
  logic [24:0] min_prod;

  assign yoe_prod = 37'(y2_t) * 37'(ucd_pkg::YOE_M);
  assign min_prod = 25'(y2_tr) * 25'(ucd_pkg::MIN_M);

  logic [ucd_pkg::DOE_W-1:0]   y3_doe;
  logic [ucd_pkg::YEAR_W-1:0]  y3_era400;
  logic [ucd_pkg::YOE_W-1:0]   y3_yoe;
  logic [ucd_pkg::HOUR_W-1:0]  y3_hour;
  logic [ucd_pkg::TR_W-1:0]    y3_tr;
  logic [ucd_pkg::MIN_W-1:0]   y3_minute;

  always_ff @(posedge clk) begin
    if (en[ST_Y+2]) begin
      y3_doe    <= y2_doe;
      y3_era400 <= y2_era400;
      y3_yoe    <= yoe_prod[ucd_pkg::YOE_SH +: ucd_pkg::YOE_W];
      y3_hour   <= y2_hour;
      y3_tr     <= y2_tr;
      y3_minute <= min_prod[ucd_pkg::MIN_SH +: ucd_pkg::MIN_W];
    end
  end

  // stage 4: year start terms, second
  logic [18:0] y100_prod;

  assign y100_prod = 19'(y3_yoe) * 19'(ucd_pkg::Y100_M);

  logic [ucd_pkg::DOE_W-1:0]   y4_doe;
  logic [ucd_pkg::YEAR_W-1:0]  y4_era400;
  logic [ucd_pkg::YOE_W-1:0]   y4_yoe;
  logic [ucd_pkg::DOE_W-1:0]   y4_y365;
  logic [ucd_pkg::Y100_W-1:0]  y4_y100;
  logic [ucd_pkg::HOUR_W-1:0]  y4_hour;
  logic [ucd_pkg::MIN_W-1:0]   y4_minute;
  logic [ucd_pkg::SEC_W-1:0]   y4_second;

  always_ff @(posedge clk) begin
    if (en[ST_Y+3]) begin
      y4_doe    <= y3_doe;
      y4_era400 <= y3_era400;
      y4_yoe    <= y3_yoe;
      y4_y365   <= ucd_pkg::DOE_W'(y3_yoe) * ucd_pkg::DAYS_PER_YEAR;
      y4_y100   <= y100_prod[ucd_pkg::Y100_SH +: ucd_pkg::Y100_W];
      y4_hour   <= y3_hour;
      y4_minute <= y3_minute;
      y4_second <= ucd_pkg::SEC_W'(y3_tr - ucd_pkg::TR_W'(y3_minute) *
                                  ucd_pkg::SECS_PER_MIN);
    end
  end

  // stage 5: day of year
  logic [ucd_pkg::DOY_W-1:0]   y5_doy;
  logic [ucd_pkg::YEAR_W-1:0]  y5_era400;
  logic [ucd_pkg::YOE_W-1:0]   y5_yoe;
  logic [ucd_pkg::HOUR_W-1:0]  y5_hour;
  logic [ucd_pkg::MIN_W-1:0]   y5_minute;
  logic [ucd_pkg::SEC_W-1:0]   y5_second;

  always_ff @(posedge clk) begin
    if (en[ST_Y+4]) begin
      y5_doy    <= ucd_pkg::DOY_W'(y4_doe - (y4_y365 +
                   ucd_pkg::DOE_W'(y4_yoe[ucd_pkg::YOE_W-1:2]) -
                   ucd_pkg::DOE_W'(y4_y100)));
      y5_era400 <= y4_era400;
      y5_yoe    <= y4_yoe;
      y5_hour   <= y4_hour;
      y5_minute <= y4_minute;
      y5_second <= y4_second;
    end
  end

  // stage 6: month numerator
  logic [ucd_pkg::V5_W-1:0]    y6_v5;
  logic [ucd_pkg::DOY_W-1:0]   y6_doy;
  logic [ucd_pkg::YEAR_W-1:0]  y6_era400;
  logic [ucd_pkg::YOE_W-1:0]   y6_yoe;
  logic [ucd_pkg::HOUR_W-1:0]  y6_hour;
  logic [ucd_pkg::MIN_W-1:0]   y6_minute;
  logic [ucd_pkg::SEC_W-1:0]   y6_second;

  always_ff @(posedge clk) begin
    if (en[ST_Y+5]) begin
      y6_v5     <= (ucd_pkg::V5_W'(y5_doy) << 2) + ucd_pkg::V5_W'(y5_doy) +
                   ucd_pkg::V5_W'(2);
      y6_doy    <= y5_doy;
      y6_era400 <= y5_era400;
      y6_yoe    <= y5_yoe;
      y6_hour   <= y5_hour;
      y6_minute <= y5_minute;
      y6_second <= y5_second;
    end
  end

  // stage 7: March-based month
  logic [22:0] mp_prod;

  assign mp_prod = 23'(y6_v5) * 23'(ucd_pkg::MP_M);

  logic [ucd_pkg::MP_W-1:0]    y7_mp;
  logic [ucd_pkg::DOY_W-1:0]   y7_doy;
  logic [ucd_pkg::YEAR_W-1:0]  y7_era400;
  logic [ucd_pkg::YOE_W-1:0]   y7_yoe;
  logic [ucd_pkg::HOUR_W-1:0]  y7_hour;
  logic [ucd_pkg::MIN_W-1:0]   y7_minute;
  logic [ucd_pkg::SEC_W-1:0]   y7_second;

  always_ff @(posedge clk) begin
    if (en[ST_Y+6]) begin
      y7_mp     <= mp_prod[ucd_pkg::MP_SH +: ucd_pkg::MP_W];
      y7_doy    <= y6_doy;
      y7_era400 <= y6_era400;
      y7_yoe    <= y6_yoe;
      y7_hour   <= y6_hour;
      y7_minute <= y6_minute;
      y7_second <= y6_second;
    end
  end

  // stage 8: move January and February to the next year
  logic                        jan_feb;

  assign jan_feb = (y7_mp >= ucd_pkg::MP_JAN);

  logic [ucd_pkg::YEAR_W-1:0]  y8_year;
  logic [ucd_pkg::MONTH_W-1:0] y8_month;
  logic [ucd_pkg::DAY_W-1:0]   y8_day;
  logic [ucd_pkg::HOUR_W-1:0]  y8_hour;
  logic [ucd_pkg::MIN_W-1:0]   y8_minute;
  logic [ucd_pkg::SEC_W-1:0]   y8_second;

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      y8_year   <= y7_era400 + ucd_pkg::YEAR_W'(y7_yoe) + ucd_pkg::YEAR_W'(jan_feb);
      y8_month  <= jan_feb ? y7_mp - ucd_pkg::MONTH_W'(9) : y7_mp + ucd_pkg::MONTH_W'(3);
      y8_day    <= ucd_pkg::DAY_W'(y7_doy - ucd_pkg::month_start(y7_mp) +
                                  ucd_pkg::DOY_W'(1));
      y8_hour   <= y7_hour;
      y8_minute <= y7_minute;
      y8_second <= y7_second;
    end
  end

  assign civil.valid  = vld[NSTG-1];
  assign civil.year   = y8_year;
  assign civil.month  = y8_month;
  assign civil.day    = y8_day;
  assign civil.hour   = y8_hour;
  assign civil.minute = y8_minute;
  assign civil.second = y8_second;

endmodule

// ===== tb/unix_seconds_to_civil_datetime_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the Unix seconds to civil date and time converter.
module unix_seconds_to_civil_datetime_tb;

  typedef struct packed {
    logic [ucd_pkg::YEAR_W-1:0]  year;
    logic [ucd_pkg::MONTH_W-1:0] month;
    logic [ucd_pkg::DAY_W-1:0]   day;
    logic [ucd_pkg::HOUR_W-1:0]  hour;
    logic [ucd_pkg::MIN_W-1:0]   minute;
    logic [ucd_pkg::SEC_W-1:0]   second;
  } civil_t;

  localparam logic [63:0] LAST_WHOLE_DAY = 64'd213503982334601;

  logic clk;
  logic rst;

  ucd_in_if  stamp ();
  ucd_out_if civil ();

  unix_seconds_to_civil_datetime dut (
    .clk   (clk),
    .rst   (rst),
    .stamp (stamp),
    .civil (civil)
  );

  civil_t      civil_due[$];
  civil_t      civil_want;
  int unsigned stamps_taken = 0;
  int unsigned failures = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("unix_seconds_to_civil_datetime_tb: FAIL");
    $finish;
  end

  function automatic civil_t civil_of_seconds(input logic [63:0] secs);
    logic [63:0] days, z, era, doe, yoe, doy, mp, mday, mon, yr;
    civil_t c;
    days = secs / 64'd86400;
    z    = days + 64'd719468;
    era  = z / 64'd146097;
    doe  = z - era * 64'd146097;
    yoe  = (doe - doe / 64'd1460 + doe / 64'd36524 - doe / 64'd146096) / 64'd365;
    doy  = doe - (64'd365 * yoe + yoe / 64'd4 - yoe / 64'd100);
    mp   = (64'd5 * doy + 64'd2) / 64'd153;
    mday = doy - (64'd153 * mp + 64'd2) / 64'd5 + 64'd1;
    mon  = (mp < 64'd10) ? mp + 64'd3 : mp - 64'd9;
    yr   = yoe + era * 64'd400 + ((mon <= 64'd2) ? 64'd1 : 64'd0);
    c.year   = yr[ucd_pkg::YEAR_W-1:0];
    c.month  = mon[ucd_pkg::MONTH_W-1:0];
    c.day    = mday[ucd_pkg::DAY_W-1:0];
    c.hour   = ucd_pkg::HOUR_W'((secs / 64'd3600) % 64'd24);
    c.minute = ucd_pkg::MIN_W'((secs / 64'd60) % 64'd60);
    c.second = ucd_pkg::SEC_W'(secs % 64'd60);
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    failures++;
  endtask

  always @(posedge clk) begin
    if (stamp.valid && stamp.ready) begin
      civil_due = {civil_due, civil_of_seconds(stamp.unix_seconds)};
      stamps_taken++;
    end
    if (civil.valid && civil.ready) begin
      if (civil_due.size() == 0) begin
        report_mismatch("result with no request pending", civil.year, 0);
      end else begin
        civil_want = civil_due.pop_front();
        if (civil.year !== civil_want.year)
          report_mismatch("year", civil.year, civil_want.year);
        if (civil.month !== civil_want.month)
          report_mismatch("month", civil.month, civil_want.month);
        if (civil.day !== civil_want.day)
          report_mismatch("day", civil.day, civil_want.day);
        if (civil.hour !== civil_want.hour)
          report_mismatch("hour", civil.hour, civil_want.hour);
        if (civil.minute !== civil_want.minute)
          report_mismatch("minute", civil.minute, civil_want.minute);
        if (civil.second !== civil_want.second)
          report_mismatch("second", civil.second, civil_want.second);
      end
    end
  end

  always @(negedge clk) begin
    civil.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Call at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_stamp(input logic [63:0] secs);
    int unsigned target;
    while ($urandom_range(99) < send_idle_pct) begin
      stamp.valid <= 1'b0;
      @(negedge clk);
    end
    stamp.valid        <= 1'b1;
    stamp.unix_seconds <= secs;
    target = stamps_taken + 1;
    do @(negedge clk); while (stamps_taken < target);
  endtask

  task automatic wait_drained();
    stamp.valid <= 1'b0;
    while (civil_due.size() != 0) @(negedge clk);
  endtask

  function automatic logic [63:0] pick_stamp();
    logic [63:0] days, era, yoe, doy;
    case ($urandom_range(4))
      0: return {$urandom, $urandom};
      1: return {28'd0, 4'($urandom_range(15)), $urandom};
      2: begin
        days = {$urandom, $urandom} % LAST_WHOLE_DAY;
        case ($urandom_range(3))
          0: return days * 64'd86400;
          1: return days * 64'd86400 + 64'd1;
          2: return days * 64'd86400 + 64'd86399;
          default: return days * 64'd86400 + 64'($urandom_range(86399));
        endcase
      end
      3: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(200_000_000));
      default: begin
        // land near the end of February in a chosen year of a 400-year cycle
        era = $urandom_range(1) ? 64'($urandom_range(12, 5))
                                : 64'($urandom_range(1_400_000_000, 5));
        yoe = $urandom_range(1) ? 64'($urandom_range(399))
                                : 64'(100 * $urandom_range(3) + $urandom_range(3));
        doy = $urandom_range(1) ? 64'($urandom_range(365, 362)) : 64'($urandom_range(1));
        days = era * 64'd146097 + 64'd365 * yoe + yoe / 64'd4 - yoe / 64'd100 + doy
               - 64'd719468;
        return days * 64'd86400 + 64'($urandom_range(86399));
      end
    endcase
  endfunction

  task automatic test_calendar_edges();
    logic [63:0] edges[$];
    edges = '{64'd0, 64'd59, 64'd3599, 64'd86399, 64'd86400,
              64'd31535999, 64'd31536000, 64'd68169599, 64'd68169600,
              64'd946684799, 64'd946684800, 64'd951782400, 64'd951868799,
              64'd951868800, 64'd4107542399, 64'd4107542400, 64'd13574563200,
              64'd2147483647, 64'd2147483648, 64'd4294967295, 64'd4294967296,
              64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFE,
              64'hFFFF_FFFF_FFFF_FFFF};
    foreach (edges[i]) send_stamp(edges[i]);
  endtask

  task automatic test_random_stamps(input int unsigned count);
    repeat (count) send_stamp(pick_stamp());
  endtask

  task automatic test_pause_until_drained();
    repeat (10) send_stamp(pick_stamp());
    wait_drained();
    repeat (10) send_stamp(pick_stamp());
  endtask

  initial begin
    rst                = 1'b1;
    stamp.valid        = 1'b0;
    stamp.unix_seconds = '0;
    civil.ready        = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 27;
    recv_idle_pct = 47;
    test_calendar_edges();
    test_random_stamps(550);
    test_pause_until_drained();

    send_idle_pct = 47;
    recv_idle_pct = 27;
    test_random_stamps(530);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stamps(530);

    wait_drained();
    repeat (40) @(negedge clk);
    if (failures == 0) begin
      $display("unix_seconds_to_civil_datetime_tb: PASS");
    end else begin
      $display("unix_seconds_to_civil_datetime_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ucd_pkg.sv
rtl/ucd_in_if.sv
rtl/ucd_out_if.sv
rtl/unix_seconds_to_civil_datetime.sv
tb/unix_seconds_to_civil_datetime_tb.sv
